@@ src/csamp_pkg.sv @@
package csamp_pkg;

  // Input and result transactions
  typedef struct packed {
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
  } pose_t;

  typedef struct packed {
    logic [15:0] cell_x;
    logic [15:0] cell_y;
    logic        last;
  } cell_t;

  // Register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_ORIGIN_X  = 3'd0,
    REG_ORIGIN_Y  = 3'd1,
    REG_INV_RES   = 3'd2,
    REG_RADIUS    = 3'd3,
    REG_GRID_W    = 3'd4,
    REG_GRID_H    = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic [15:0]        inv_res;
    logic [14:0]        radius;
    logic [15:0]        grid_w;
    logic [15:0]        grid_h;
  } cfg_t;

  // Job widths cover the whole range of both parameters
  localparam int unsigned JOB_N_W   = 7;   // step count up to 64
  localparam int unsigned JOB_DQ_W  = 10;  // depth / steps up to 512
  localparam int unsigned CENTRE_W  = 52;  // (pose - origin) * inv_res * 8
  localparam int unsigned FRAC_BITS = 27;

  typedef struct packed {
    logic signed [CENTRE_W-1:0] cx;
    logic signed [CENTRE_W-1:0] cy;
    logic [JOB_N_W-1:0]         n;
    logic [JOB_DQ_W-1:0]        dq;
    logic [JOB_N_W-1:0]         dr;
  } job_t;

  localparam logic [23:0] FOUR_PI_Q20 = 24'd13176795;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1073741824;

endpackage

@@ src/csamp_queue.sv @@
module csamp_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  csamp_pkg::job_t   push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output csamp_pkg::job_t   head_o
);
  import csamp_pkg::*;

  job_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;

  assign full_o  = (fill_q == 2'd2);
  assign empty_o = (fill_q == 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  // Store jobs
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      fill_q <= fill_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

@@ src/csamp_front.sv @@
module csamp_front #(
  parameter int unsigned MAX_STEPS        = 64,
  parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  csamp_pkg::cfg_t   cfg_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  csamp_pkg::pose_t  in_data_i,
  output logic              push_o,
  output csamp_pkg::job_t   push_data_o,
  input  logic              full_i
);
  import csamp_pkg::*;

  localparam int unsigned DW  = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int unsigned CW  = $clog2(DW);
  localparam logic [DW-1:0] DNUM = DW'(SINE_TABLE_DEPTH);
  localparam logic [JOB_N_W-1:0] N_MIN = JOB_N_W'(8);
  localparam logic [JOB_N_W-1:0] N_MAX = JOB_N_W'(MAX_STEPS);

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_DIV, F_PUSH} fstate_e;

  fstate_e             state_q;
  logic signed [32:0]  dx_q, dy_q;
  logic signed [CENTRE_W-1:0] cx_q, cy_q;
  logic [JOB_N_W-1:0]  n_q;
  logic [JOB_N_W:0]    rem_q;
  logic [DW-1:0]       quo_q;
  logic [CW-1:0]       bit_q;

  logic [38:0]         n_prod;
  logic [6:0]          n_raw;
  logic [JOB_N_W-1:0]  n_clamp;
  logic signed [49:0]  px, py;
  logic [JOB_N_W+1:0]  rem_sh;
  logic                q_bit;

  assign in_stall_o = (state_q != F_IDLE);

  // Step count: ceil(radius * 4pi), kept within 8 and the step limit
  always_comb begin
    n_prod = 39'(cfg_i.radius) * 39'(FOUR_PI_Q20);
    n_raw  = 7'((n_prod + 39'h0_FFFF_FFFF) >> 32);
    if (n_raw < N_MIN)      n_clamp = N_MIN;
    else if (n_raw > N_MAX) n_clamp = N_MAX;
    else                    n_clamp = n_raw;
  end

  assign px = dx_q * $signed({1'b0, cfg_i.inv_res});
  assign py = dy_q * $signed({1'b0, cfg_i.inv_res});

  // One restoring step of depth / n
  always_comb begin
    rem_sh = {rem_q, DNUM[bit_q]};
    q_bit  = (rem_sh >= {2'b00, n_q});
  end

  assign push_o = (state_q == F_PUSH) && !full_i;
  always_comb begin
    push_data_o.cx = cx_q;
    push_data_o.cy = cy_q;
    push_data_o.n  = n_q;
    push_data_o.dq = JOB_DQ_W'(quo_q);
    push_data_o.dr = rem_q[JOB_N_W-1:0];
  end

  // Accept, scale to grid units, divide the turn into steps, hand over
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      dx_q    <= '0;
      dy_q    <= '0;
      cx_q    <= '0;
      cy_q    <= '0;
      n_q     <= '0;
      rem_q   <= '0;
      quo_q   <= '0;
      bit_q   <= '0;
    end else begin
      unique case (state_q)
        F_IDLE: begin
          if (in_valid_i && (cfg_i.inv_res != 16'd0)) begin
            dx_q    <= {in_data_i.pose_x[31], in_data_i.pose_x}
                       - {cfg_i.origin_x[31], cfg_i.origin_x};
            dy_q    <= {in_data_i.pose_y[31], in_data_i.pose_y}
                       - {cfg_i.origin_y[31], cfg_i.origin_y};
            state_q <= F_MUL;
          end
        end
        F_MUL: begin
          cx_q    <= CENTRE_W'({px, 3'b000});
          cy_q    <= CENTRE_W'({py, 3'b000});
          n_q     <= n_clamp;
          rem_q   <= '0;
          quo_q   <= '0;
          bit_q   <= CW'(DW - 1);
          state_q <= F_DIV;
        end
        F_DIV: begin
          rem_q <= q_bit ? (JOB_N_W+1)'(rem_sh - {2'b00, n_q}) : (JOB_N_W+1)'(rem_sh);
          quo_q <= {quo_q[DW-2:0], q_bit};
          if (bit_q == '0) state_q <= F_PUSH;
          else             bit_q   <= bit_q - 1'b1;
        end
        F_PUSH: begin
          if (!full_i) state_q <= F_IDLE;
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

@@ src/csamp_back.sv @@
module csamp_back #(
  parameter int unsigned MAX_STEPS        = 64,
  parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  csamp_pkg::cfg_t   cfg_i,
  input  logic              empty_i,
  input  csamp_pkg::job_t   job_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output csamp_pkg::cell_t  out_data_o
);
  import csamp_pkg::*;

  localparam int unsigned Quarter = SINE_TABLE_DEPTH / 4;
  localparam int unsigned QW  = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int unsigned RW  = $clog2(Quarter + 1);
  localparam int unsigned KW  = $clog2(MAX_STEPS + 2);
  localparam int unsigned SW  = CENTRE_W + 1;
  localparam logic [QW:0] DEPTH_K = (QW+1)'(SINE_TABLE_DEPTH);
  localparam logic [QW:0] QUART_K = (QW+1)'(Quarter);
  localparam logic [QW:0] HALF_K  = (QW+1)'(2 * Quarter);
  localparam logic [QW:0] TRIQ_K  = (QW+1)'(3 * Quarter);
  localparam logic [KW-1:0] CNT_FULL = KW'(MAX_STEPS + 1);

  typedef logic [15:0] rom_t [Quarter+1];

  function automatic logic [15:0] quarter_sine(input int unsigned r);
    longint unsigned x, x2, t, s;
    x  = longint'(r) * HALF_PI_Q30 / Quarter;
    x2 = (x * x) >> 30;
    t  = ONE_Q30 - x2 / 72;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 42;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
    s  = (x * t) >> 30;
    s  = (s + 64'd16384) >> 15;
    if (s > 64'd32767) s = 64'd32767;
    return 16'(s);
  endfunction

  function automatic rom_t build_rom();
    rom_t rom;
    for (int unsigned r = 0; r <= Quarter; r++) rom[r] = quarter_sine(r);
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  // Fold a phase onto the quarter wave: {negate, index}
  function automatic logic [RW:0] fold(input logic [QW:0] k);
    logic [QW:0] r;
    logic        neg;
    logic        odd;
    neg = 1'b0;
    odd = 1'b0;
    r   = k;
    if (k >= TRIQ_K) begin
      r = k - TRIQ_K; neg = 1'b1; odd = 1'b1;
    end else if (k >= HALF_K) begin
      r = k - HALF_K; neg = 1'b1;
    end else if (k >= QUART_K) begin
      r = k - QUART_K; odd = 1'b1;
    end
    if (odd) r = QUART_K - r;
    return {neg, RW'(r)};
  endfunction

  typedef enum logic [2:0] {B_IDLE, B_RUN, B_DRAIN, B_FIN1, B_FIN2} bstate_e;

  bstate_e            state_q;
  logic               en;
  logic [JOB_N_W-1:0] i_q;
  logic [QW-1:0]      qacc_q;
  logic [JOB_N_W-1:0] racc_q;

  logic               s1_vld_q, s2_vld_q;
  logic               sneg_q, cneg_q;
  logic [15:0]        rom_s_q, rom_c_q;
  logic signed [32:0] ps_q, pc_q;

  logic               a_vld_q, b_vld_q;
  logic [15:0]        ax_q, ay_q, bx_q, by_q, fx_q, fy_q;
  logic [KW-1:0]      cnt_q;

  logic               out_vld_q;
  cell_t              out_q;

  logic [QW:0]        ph_raw, ph, ch_raw, ch;
  logic [RW:0]        sfold, cfold;
  logic [JOB_N_W:0]   rsum;
  logic               carry;
  logic signed [16:0] sval, cval;
  logic signed [SW-1:0] sum_x, sum_y;
  logic signed [SW-FRAC_BITS-1:0] cell_x, cell_y;
  logic               inb, take, emit3, drop_b;

  assign en = !out_vld_q || !out_stall_i;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // Phase of the current step and of its cosine partner
  always_comb begin
    ph_raw = QUART_K + {1'b0, qacc_q};
    ph     = (ph_raw >= DEPTH_K) ? ph_raw - DEPTH_K : ph_raw;
    ch_raw = ph + QUART_K;
    ch     = (ch_raw >= DEPTH_K) ? ch_raw - DEPTH_K : ch_raw;
    sfold  = fold(ph);
    cfold  = fold(ch);
    rsum   = {1'b0, racc_q} + {1'b0, job_i.dr};
    carry  = (rsum >= {1'b0, job_i.n});
  end

  // Candidate cell from the product stage
  always_comb begin
    sval   = sneg_q ? -$signed({1'b0, rom_s_q}) : $signed({1'b0, rom_s_q});
    cval   = cneg_q ? -$signed({1'b0, rom_c_q}) : $signed({1'b0, rom_c_q});
    sum_x  = SW'(job_i.cx) + SW'(pc_q);
    sum_y  = SW'(job_i.cy) + SW'(ps_q);
    cell_x = sum_x[SW-1:FRAC_BITS];
    cell_y = sum_y[SW-1:FRAC_BITS];
    inb    = !cell_x[SW-FRAC_BITS-1] && !cell_y[SW-FRAC_BITS-1]
             && (cell_x < $signed({10'd0, cfg_i.grid_w}))
             && (cell_y < $signed({10'd0, cfg_i.grid_h}));
    take   = s2_vld_q && inb
             && !(b_vld_q && (bx_q == cell_x[15:0]) && (by_q == cell_y[15:0]));
    emit3  = take && a_vld_q && b_vld_q;
    drop_b = b_vld_q && (((cnt_q > KW'(1)) && (bx_q == fx_q) && (by_q == fy_q))
                         || (cnt_q == CNT_FULL));
  end

  assign pop_o = (state_q == B_FIN2) && en;

  // Sequence steps, hold back two cells, close the circle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= B_IDLE;
      i_q       <= '0;
      qacc_q    <= '0;
      racc_q    <= '0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      a_vld_q   <= 1'b0;
      b_vld_q   <= 1'b0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      s2_vld_q  <= s1_vld_q;
      s1_vld_q  <= (state_q == B_RUN);
      out_vld_q <= emit3 || ((state_q == B_FIN1) && a_vld_q)
                   || ((state_q == B_FIN2) && b_vld_q && !drop_b);

      // Clear the held cells for a new job, or take in a candidate
      if ((state_q == B_IDLE) && !empty_i) begin
        a_vld_q <= 1'b0;
        b_vld_q <= 1'b0;
        cnt_q   <= '0;
      end else if (take) begin
        cnt_q <= cnt_q + 1'b1;
        if (!b_vld_q) begin
          b_vld_q <= 1'b1;
        end else begin
          a_vld_q <= 1'b1;
        end
      end

      unique case (state_q)
        B_IDLE: begin
          if (!empty_i) begin
            i_q     <= '0;
            qacc_q  <= '0;
            racc_q  <= job_i.n >> 1;
            state_q <= B_RUN;
          end
        end
        B_RUN: begin
          qacc_q   <= qacc_q + QW'(job_i.dq) + QW'(carry);
          racc_q   <= carry ? JOB_N_W'(rsum - {1'b0, job_i.n})
                            : JOB_N_W'(rsum);
          i_q      <= i_q + 1'b1;
          if (i_q == job_i.n) state_q <= B_DRAIN;
        end
        B_DRAIN: begin
          if (!s1_vld_q && !s2_vld_q) state_q <= B_FIN1;
        end
        B_FIN1: begin
          state_q <= B_FIN2;
        end
        B_FIN2: begin
          state_q <= B_IDLE;
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  // Datapath registers: table read, products, held cells, result
  always_ff @(posedge clk_i) begin
    if (en) begin
      rom_s_q <= SINE_ROM[sfold[RW-1:0]];
      rom_c_q <= SINE_ROM[cfold[RW-1:0]];
      sneg_q  <= sfold[RW];
      cneg_q  <= cfold[RW];
      ps_q    <= $signed({1'b0, cfg_i.radius}) * sval;
      pc_q    <= $signed({1'b0, cfg_i.radius}) * cval;
      if (take) begin
        bx_q <= cell_x[15:0];
        by_q <= cell_y[15:0];
        if (b_vld_q) begin
          ax_q <= bx_q;
          ay_q <= by_q;
        end
        if (cnt_q == '0) begin
          fx_q <= cell_x[15:0];
          fy_q <= cell_y[15:0];
        end
        if (emit3) begin
          out_q.cell_x <= ax_q;
          out_q.cell_y <= ay_q;
          out_q.last   <= 1'b0;
        end
      end
      if (state_q == B_FIN1) begin
        out_q.cell_x <= ax_q;
        out_q.cell_y <= ay_q;
        out_q.last   <= drop_b;
      end
      if (state_q == B_FIN2) begin
        out_q.cell_x <= bx_q;
        out_q.cell_y <= by_q;
        out_q.last   <= 1'b1;
      end
    end
  end

endmodule

@@ src/circle_perimeter_cell_sampler.sv @@
// Circle perimeter cell sampler.
// Input channel (in_valid_i / in_stall_o / in_data_i) takes one robot pose
// per transaction; the output channel (out_valid_o / out_stall_i /
// out_data_o) returns the grid cells on the configured circle around it,
// with last set on the final cell of each pose. A pose that yields no cell
// returns nothing.
// The front takes a pose, scales it to grid units and divides the turn into
// n steps, then queues the job (two deep). The back walks the n+1 angle
// steps at one per cycle while the output is not stalled, through the sine
// table, product and cell stages. Poses overlap: the front prepares the
// next one while the back works.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i;
// the user must write it only while the block is idle, which the block
// itself does not enforce. Unknown indexes are ignored.
// Reset clears the queue, both sequencers and the output valid flag and
// restores the register defaults. A stall on the output holds the result
// and freezes the back; the queue then fills and the input stalls.
module circle_perimeter_cell_sampler #(
  parameter int unsigned MAX_STEPS        = 64,
  parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [31:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  csamp_pkg::pose_t    in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output csamp_pkg::cell_t    out_data_o
);
  import csamp_pkg::*;

  cfg_t cfg_q;
  logic push, full, pop, empty;
  job_t push_data, head;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x <= '0;
      cfg_q.origin_y <= '0;
      cfg_q.inv_res  <= 16'd5120;
      cfg_q.radius   <= 15'd4096;
      cfg_q.grid_w   <= 16'd1024;
      cfg_q.grid_h   <= 16'd1024;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ORIGIN_X: cfg_q.origin_x <= cfg_data_i;
        REG_ORIGIN_Y: cfg_q.origin_y <= cfg_data_i;
        REG_INV_RES:  cfg_q.inv_res  <= cfg_data_i[15:0];
        REG_RADIUS:   cfg_q.radius   <= cfg_data_i[14:0];
        REG_GRID_W:   cfg_q.grid_w   <= cfg_data_i[15:0];
        REG_GRID_H:   cfg_q.grid_h   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  csamp_front #(
    .MAX_STEPS        (MAX_STEPS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  csamp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  csamp_back #(
    .MAX_STEPS        (MAX_STEPS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .empty_i     (empty),
    .job_i       (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
